// ===== rtl/core/inorder_core_timing_scoreboard_defines.svh =====
// ----------------------------------------------------------------------------
// Scoreboard assertion macros
// Assertion helpers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef INORDER_CORE_TIMING_SCOREBOARD_DEFINES_SVH
`define INORDER_CORE_TIMING_SCOREBOARD_DEFINES_SVH
`ifndef SYNTHESIS
`define ICTS_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ICTS_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define ICTS_ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define ICTS_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg)
`endif
`endif

// ===== rtl/core/icts_pkg.sv =====
// ----------------------------------------------------------------------------
// icts_pkg
// Types, constants and state codes for the timing scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none
package icts_pkg;
  localparam int NUM_REGS      = 512;
  localparam int LOAD_SLOTS    = 3;
  localparam int STORE_ENTRIES = 1;
  localparam int REG_AW        = $clog2(NUM_REGS);

  typedef enum logic [2:0] {
    OP_BEGIN = 3'd0, OP_RREAD = 3'd1, OP_LOAD = 3'd2,
    OP_RWRITE = 3'd3, OP_STORE = 3'd4, OP_END = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [8:0]  reg_index;
    logic [63:0] address;
    logic [15:0] latency;
    logic [15:0] cost;
    logic        simple_load;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] cycle_count;
    logic [63:0] item_time;
    logic        forwarded;
    logic [63:0] instructions_done;
  } out_beat_t;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EXEC, ST_OUT} state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } dp_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/core/icts_ctrl.sv =====
// ----------------------------------------------------------------------------
// icts_ctrl
// Sequencer: capture, scoreboard read, execute, present result.
// ----------------------------------------------------------------------------
`default_nettype none
module icts_ctrl import icts_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic out_stall,
  input  wire logic clr_busy,
  output logic      in_stall,
  output logic      out_valid,
  output dp_cmd_t   cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid && !clr_busy) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_stall) state_nxt = in_valid ? ST_READ : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid = (state_r == ST_OUT);
    in_stall  = clr_busy ||
                !((state_r == ST_IDLE) || (state_r == ST_OUT && !out_stall));
    cmd.capture  = in_valid && !in_stall;
    cmd.exec     = (state_r == ST_EXEC);
  end
endmodule
`default_nettype wire

// ===== rtl/core/icts_dp.sv =====
// ----------------------------------------------------------------------------
// icts_dp
// Scoreboard memory, load slots, store buffer and timing registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "inorder_core_timing_scoreboard_defines.svh"
module icts_dp import icts_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  dp_cmd_t   cmd,
  input  in_beat_t  in_data,
  output out_beat_t out_data,
  output logic      clr_busy
);
  logic [63:0] sb_mem [NUM_REGS];
  logic [63:0] sb_rd_r;
  in_beat_t    it_r;
  logic              clr_r;
  logic [REG_AW-1:0] clr_idx_r;

  logic [63:0] cycles_r, ops_r, lst_r, ret_r;
  logic [15:0] wll_r, cost_r;
  logic        simple_r;
  logic [63:0] ld_r [LOAD_SLOTS];
  logic [63:0] sb_busy_r [STORE_ENTRIES];
  logic [63:0] sb_addr_r [STORE_ENTRIES];
  logic [63:0] res_time_r;
  logic        res_fwd_r;

  logic        in_rng;
  assign in_rng = ({3'd0, it_r.reg_index} < 12'(NUM_REGS));

  logic [63:0] e_t;
  assign e_t = ops_r + {48'd0, wll_r} + {48'd0, cost_r};

  always_ff @(posedge clk) begin
    if (cmd.capture) it_r <= in_data;
  end

  // one entry zeroed per cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1; clr_idx_r <= '0;
    end else if (clr_r) begin
      clr_idx_r <= clr_idx_r + REG_AW'(1);
      if (clr_idx_r == REG_AW'(NUM_REGS-1)) clr_r <= 1'b0;
    end
  end

  assign clr_busy = clr_r;

  always_ff @(posedge clk) begin
    if (clr_r) sb_mem[clr_idx_r] <= '0;
    else if (cmd.exec && it_r.op == OP_RWRITE && in_rng)
      sb_mem[it_r.reg_index[REG_AW-1:0]] <= e_t;
    sb_rd_r <= sb_mem[it_r.reg_index[REG_AW-1:0]];
  end

  logic [63:0] rd_val;
  assign rd_val = in_rng ? sb_rd_r : 64'd0;

  // load claim
  logic        hit, ld_free;
  logic [$clog2(LOAD_SLOTS+1)-1:0] ld_fi, ld_bi;
  logic [63:0] ld_t;
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < STORE_ENTRIES; i++)
      if (sb_addr_r[i] == it_r.address && sb_busy_r[i] >= ops_r) hit = 1'b1;
    ld_free = 1'b0; ld_fi = '0; ld_bi = '0;
    for (int i = LOAD_SLOTS-1; i >= 0; i--)
      if (ld_r[i] <= ops_r) begin ld_free = 1'b1; ld_fi = ($bits(ld_fi))'(i); end
    for (int i = 1; i < LOAD_SLOTS; i++)
      if (ld_r[i] < ld_r[ld_bi]) ld_bi = ($bits(ld_bi))'(i);
    ld_t = ld_free ? ops_r : ld_r[ld_bi];
  end

  // store claim
  logic        st_m, st_free;
  logic [$clog2(STORE_ENTRIES+1)-1:0] st_mi, st_fi, st_bi, st_w;
  logic [63:0] st_t;
  always_comb begin
    st_m = 1'b0; st_mi = '0; st_free = 1'b0; st_fi = '0; st_bi = '0;
    for (int i = STORE_ENTRIES-1; i >= 0; i--)
      if (sb_addr_r[i] == it_r.address) begin st_m = 1'b1; st_mi = ($bits(st_mi))'(i); end
    for (int i = STORE_ENTRIES-1; i >= 0; i--)
      if (sb_busy_r[i] <= e_t) begin st_free = 1'b1; st_fi = ($bits(st_fi))'(i); end
    for (int i = 1; i < STORE_ENTRIES; i++)
      if (sb_busy_r[i] < sb_busy_r[st_bi]) st_bi = ($bits(st_bi))'(i);
    st_w = st_m ? st_mi : (st_free ? st_fi : st_bi);
    st_t = (st_m || st_free) ? e_t : sb_busy_r[st_bi];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycles_r <= '0; ops_r <= '0; lst_r <= '0; ret_r <= '0;
      wll_r <= '0; cost_r <= '0; simple_r <= 1'b0;
      for (int i = 0; i < LOAD_SLOTS; i++) ld_r[i] <= '0;
      for (int i = 0; i < STORE_ENTRIES; i++) begin
        sb_busy_r[i] <= '0; sb_addr_r[i] <= '0;
      end
    end else if (cmd.exec) begin
      res_fwd_r <= 1'b0;
      case (it_r.op)
        OP_BEGIN: begin
          cycles_r <= cycles_r + {48'd0, it_r.latency} - 64'd1;
          ops_r <= cycles_r + {48'd0, it_r.latency} - 64'd1;
          res_time_r <= cycles_r + {48'd0, it_r.latency} - 64'd1;
          wll_r <= '0; lst_r <= '0;
          cost_r <= it_r.cost; simple_r <= it_r.simple_load;
        end
        OP_RREAD: begin
          ops_r <= (ops_r < rd_val) ? rd_val : ops_r;
          res_time_r <= (ops_r < rd_val) ? rd_val : ops_r;
        end
        OP_LOAD: begin
          if (hit) begin
            res_fwd_r <= 1'b1; res_time_r <= ops_r;
          end else begin
            if (ld_free) ld_r[ld_fi] <= ops_r + {48'd0, it_r.latency};
            else ld_r[ld_bi] <= ld_r[ld_bi] + {48'd0, it_r.latency};
            if (wll_r < it_r.latency) wll_r <= it_r.latency;
            if (ops_r < ld_t) ops_r <= ld_t;
            res_time_r <= ld_t;
          end
        end
        OP_RWRITE: begin
          res_time_r <= ops_r;
        end
        OP_STORE: begin
          sb_busy_r[st_w] <= st_t + {48'd0, it_r.latency};
          sb_addr_r[st_w] <= it_r.address;
          if (lst_r < st_t) lst_r <= st_t;
          res_time_r <= st_t;
        end
        OP_END: begin
          if (simple_r) cycles_r <= ops_r + {48'd0, cost_r};
          else cycles_r <= (e_t < lst_r) ? lst_r : e_t;
          ret_r <= ret_r + 64'd1;
          res_time_r <= ops_r;
        end
        default: res_time_r <= ops_r;
      endcase
    end
  end

  assign out_data.cycle_count       = cycles_r;
  assign out_data.item_time         = res_time_r;
  assign out_data.forwarded         = res_fwd_r;
  assign out_data.instructions_done = ret_r;

  `ICTS_ASSERT_NEXT(a_ret, clk, rst_n, cmd.exec && it_r.op == OP_END, ret_r == $past(ret_r) + 64'd1, "retire count")
  `ICTS_ASSERT_NEXT(a_ret_hold, clk, rst_n, !cmd.exec, $stable(ret_r), "retire count moved")
  `ICTS_ASSERT_IMPL(a_cmd, clk, rst_n, !(cmd.exec && cmd.capture), "capture during exec")
endmodule
`default_nettype wire

// ===== rtl/core/inorder_core_timing_scoreboard.sv =====
// ----------------------------------------------------------------------------
// inorder_core_timing_scoreboard
// Timing model of an in-order core with out-of-order memory.
// ----------------------------------------------------------------------------
// Each beat yields one result beat. An item passes from accept to result through
// the scoreboard read, execute and present states; a new beat is taken in the cycle
// its predecessor's result is delivered, so a new beat is not taken while one is in
// flight. The read state is there for the registered read of the register scoreboard
// memory. After reset the scoreboard memory is zeroed one entry per cycle, so
// the input stalls until every entry is cleared.
`default_nettype none
module inorder_core_timing_scoreboard import icts_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_beat_t out_data
);
  dp_cmd_t cmd;
  logic    clr_busy;

  icts_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .out_stall, .clr_busy, .in_stall, .out_valid, .cmd
  );

  icts_dp u_dp (
    .clk, .rst_n, .cmd, .in_data, .out_data, .clr_busy
  );
endmodule
`default_nettype wire

// ===== tb/sv/inorder_core_timing_scoreboard_tb.sv =====
// ----------------------------------------------------------------------------
// inorder_core_timing_scoreboard_tb
// Drives instruction item runs into the timing scoreboard and checks each
// result beat against a behavioural predictor kept inside the testbench.
// ----------------------------------------------------------------------------
`default_nettype none
module inorder_core_timing_scoreboard_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import icts_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  inorder_core_timing_scoreboard dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [63:0] cycles_q;
  logic [63:0] reg_ready [NUM_REGS];
  logic [63:0] load_busy [LOAD_SLOTS];
  logic [63:0] store_busy [STORE_ENTRIES];
  logic [63:0] store_addr [STORE_ENTRIES];
  logic [63:0] opnd_ready;
  logic [15:0] worst_lat;
  logic [63:0] last_store;
  logic [15:0] held_cost_q;
  logic        held_simple_q;
  logic [63:0] retired_q;

  out_beat_t expected_q [$];
  int  mismatches = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_fwd = 0;
  bit  quiet = 1'b0;
  int  idle_cycles = 0;
  int  stall_left = 0;

  function automatic logic [63:0] completion();
    return opnd_ready + 64'(worst_lat) + 64'(held_cost_q);
  endfunction

  function automatic logic [63:0] claim_load(logic [63:0] t, logic [63:0] occ);
    int best;
    logic [63:0] start;
    best = 0;
    for (int i = 0; i < LOAD_SLOTS; i++) begin
      if (load_busy[i] <= t) begin
        load_busy[i] = t + occ;
        return t;
      end
      if (load_busy[i] < load_busy[best]) best = i;
    end
    start = load_busy[best];
    load_busy[best] = start + occ;
    return start;
  endfunction

  function automatic logic [63:0] place_store(logic [63:0] t, logic [63:0] occ,
                                              logic [63:0] a);
    int best;
    logic [63:0] start;
    best = 0;
    for (int i = 0; i < STORE_ENTRIES; i++)
      if (store_addr[i] == a) begin
        store_busy[i] = t + occ;
        return t;
      end
    for (int i = 0; i < STORE_ENTRIES; i++) begin
      if (store_busy[i] <= t) begin
        store_busy[i] = t + occ;
        store_addr[i] = a;
        return t;
      end
      if (store_busy[i] < store_busy[best]) best = i;
    end
    start = store_busy[best];
    store_busy[best] = start + occ;
    store_addr[best] = a;
    return start;
  endfunction

  function automatic out_beat_t predict_timing(in_beat_t b);
    out_beat_t r;
    logic [63:0] t;
    logic [63:0] e;
    logic hit;
    r = '0;
    case (b.op)
      OP_BEGIN: begin
        cycles_q = cycles_q + 64'(b.latency) - 64'd1;
        opnd_ready = cycles_q;
        worst_lat = '0;
        last_store = '0;
        held_cost_q = b.cost;
        held_simple_q = b.simple_load;
        r.item_time = opnd_ready;
      end
      OP_RREAD: begin
        if (int'(b.reg_index) < NUM_REGS && opnd_ready < reg_ready[b.reg_index])
          opnd_ready = reg_ready[b.reg_index];
        r.item_time = opnd_ready;
      end
      OP_LOAD: begin
        hit = 1'b0;
        for (int i = 0; i < STORE_ENTRIES; i++)
          if (store_addr[i] == b.address && store_busy[i] >= opnd_ready) hit = 1'b1;
        if (hit) begin
          r.forwarded = 1'b1;
          r.item_time = opnd_ready;
        end else begin
          t = claim_load(opnd_ready, 64'(b.latency));
          if (worst_lat < b.latency) worst_lat = b.latency;
          if (opnd_ready < t) opnd_ready = t;
          r.item_time = t;
        end
      end
      OP_RWRITE: begin
        if (int'(b.reg_index) < NUM_REGS) reg_ready[b.reg_index] = completion();
        r.item_time = opnd_ready;
      end
      OP_STORE: begin
        t = place_store(completion(), 64'(b.latency), b.address);
        if (last_store < t) last_store = t;
        r.item_time = t;
      end
      OP_END: begin
        if (held_simple_q) cycles_q = opnd_ready + 64'(held_cost_q);
        else begin
          e = completion();
          cycles_q = (e < last_store) ? last_store : e;
        end
        retired_q++;
        r.item_time = opnd_ready;
      end
      default: r.item_time = opnd_ready;
    endcase
    r.cycle_count = cycles_q;
    r.instructions_done = retired_q;
    return r;
  endfunction

  initial begin
    cycles_q = '0; opnd_ready = '0; worst_lat = '0; last_store = '0;
    held_cost_q = '0; held_simple_q = 1'b0; retired_q = '0;
    foreach (reg_ready[i]) reg_ready[i] = '0;
    foreach (load_busy[i]) load_busy[i] = '0;
    foreach (store_busy[i]) begin
      store_busy[i] = '0;
      store_addr[i] = '0;
    end
  end

  // send one beat, with optional idle burst before it
  task automatic send_beat(in_beat_t b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_timing(b));
    n_sent++;
  endtask

  function automatic in_beat_t mk(op_t op, logic [8:0] r, logic [63:0] a,
                                  logic [15:0] l, logic [15:0] c, logic s);
    in_beat_t b;
    b.op = op; b.reg_index = r; b.address = a;
    b.latency = l; b.cost = c; b.simple_load = s;
    return b;
  endfunction

  function automatic in_beat_t rand_beat();
    in_beat_t b;
    b.op = 3'($urandom_range(0, 7));
    b.reg_index = 9'($urandom);
    b.address = {$urandom, $urandom};
    b.latency = 16'($urandom);
    b.cost = 16'($urandom);
    b.simple_load = 1'($urandom);
    return b;
  endfunction

  // result stall bursts of random length
  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) stall_left <= stall_left - 1;
    else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(1, 19);
    end
  end

  // checker
  always @(posedge clk) begin
    out_beat_t exp_b;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        exp_b = expected_q.pop_front();
        n_checked++;
        if (out_data.forwarded) n_fwd++;
        if (out_data !== exp_b) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: exp cyc=%0h t=%0h f=%0b n=%0h got cyc=%0h t=%0h f=%0b n=%0h",
                     n_checked, exp_b.cycle_count, exp_b.item_time, exp_b.forwarded,
                     exp_b.instructions_done, out_data.cycle_count, out_data.item_time,
                     out_data.forwarded, out_data.instructions_done);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("inorder_core_timing_scoreboard_tb failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_beat(mk(OP_LOAD, 9'd0, 64'd0, 16'd5, 16'd0, 1'b0));
    send_beat(mk(OP_BEGIN, 9'd0, 64'd0, 16'd0, 16'hFFFF, 1'b0));
    send_beat(mk(OP_RREAD, 9'h1FF, 64'd0, 16'd0, 16'd0, 1'b0));
    send_beat(mk(OP_LOAD, 9'd0, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'd0, 1'b0));
    send_beat(mk(OP_LOAD, 9'd0, 64'h10, 16'd3, 16'd0, 1'b0));
    send_beat(mk(OP_LOAD, 9'd0, 64'h20, 16'd7, 16'd0, 1'b0));
    send_beat(mk(OP_LOAD, 9'd0, 64'h30, 16'd1, 16'd0, 1'b0));
    send_beat(mk(OP_RWRITE, 9'h1FF, 64'd0, 16'd0, 16'd0, 1'b0));
    send_beat(mk(OP_RWRITE, 9'd0, 64'd0, 16'd0, 16'd0, 1'b0));
    send_beat(mk(OP_STORE, 9'd0, 64'hABCD, 16'hFFFF, 16'd0, 1'b0));
    send_beat(mk(OP_END, 9'd0, 64'd0, 16'd0, 16'd0, 1'b0));
    send_beat(mk(OP_BEGIN, 9'd0, 64'd0, 16'd1, 16'd2, 1'b1));
    send_beat(mk(OP_RREAD, 9'd0, 64'd0, 16'd0, 16'd0, 1'b0));
    send_beat(mk(OP_LOAD, 9'd0, 64'hABCD, 16'd9, 16'd0, 1'b0));
    send_beat(mk(OP_STORE, 9'd0, 64'hABCD, 16'd4, 16'd0, 1'b0));
    send_beat(mk(OP_END, 9'd0, 64'd0, 16'd0, 16'd0, 1'b0));
    send_beat(mk(op_t'(3'd6), 9'd5, 64'd1, 16'd1, 16'd1, 1'b1));
    send_beat(mk(op_t'(3'd7), 9'd5, 64'd1, 16'd1, 16'd1, 1'b0));
    send_beat(mk(OP_BEGIN, 9'h1FF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    send_beat(mk(OP_END, 9'd0, 64'd0, 16'd0, 16'd0, 1'b0));
  endtask

  // well-formed instruction with random content; a few addresses so stores forward
  task automatic send_instruction();
    in_beat_t b;
    logic [63:0] pool [4];
    pool[0] = 64'h0; pool[1] = 64'h40; pool[2] = {$urandom, $urandom};
    pool[3] = 64'hFFFF_FFFF_FFFF_FFF0;
    b = rand_beat(); b.op = OP_BEGIN;
    b.latency = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
    b.cost = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
    send_beat(b);
    repeat ($urandom_range(0, 3)) begin
      b = rand_beat(); b.op = OP_RREAD; b.reg_index = 9'($urandom_range(0, 15)); send_beat(b);
    end
    repeat ($urandom_range(0, 2)) begin
      b = rand_beat(); b.op = OP_LOAD; b.address = pool[$urandom_range(0, 3)];
      b.latency = 16'($urandom_range(0, 30)); send_beat(b);
    end
    repeat ($urandom_range(0, 2)) begin
      b = rand_beat(); b.op = OP_RWRITE; b.reg_index = 9'($urandom_range(0, 15)); send_beat(b);
    end
    repeat ($urandom_range(0, 2)) begin
      b = rand_beat(); b.op = OP_STORE; b.address = pool[$urandom_range(0, 3)];
      b.latency = 16'($urandom_range(0, 30)); send_beat(b);
    end
    b = rand_beat(); b.op = OP_END; send_beat(b);
  endtask

  task automatic test_random();
    while (n_sent < 950) begin
      if (n_sent > 820) quiet = 1'b1;
      if ($urandom_range(0, 5) == 0) send_beat(rand_beat());
      else send_instruction();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d beats, checked %0d results, %0d forwarded loads, %0d mismatches",
             n_sent, n_checked, n_fwd, mismatches);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("inorder_core_timing_scoreboard_tb passed");
    else
      $display("inorder_core_timing_scoreboard_tb failed");
    $finish;
  end
endmodule
`default_nettype wire
